[hdl/bvcl_pkg.sv]
// ----------------------------------------------------------------------------
// bvcl_pkg
// Types, codes and constants shared by the battery voltage current limiter.
// ----------------------------------------------------------------------------
package bvcl_pkg;

   // restoring divider for the cap step
   localparam int unsigned DIV_W     = 24;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_W);
   localparam int unsigned DIVISOR_W = 13;

   // ceil(2^28 / 125): (x / 8) * IRC_DIV_RECIP >> 28 equals x / 1000 for x < 2^24
   localparam logic [21:0]        IRC_DIV_RECIP = 22'd2147484;

   localparam logic [12:0]        MAX_IRC_MV    = 13'd4400;
   localparam logic               MULTI_FV_ON   = 1'b1;
   localparam logic signed [14:0] STEP_DBL_MA   = 15'sd3200;
   localparam logic [10:0]        IRC_RANGE_1   = 11'd1000;
   localparam logic [10:0]        IRC_RANGE_2   = 11'd2000;
   localparam logic [6:0]         SOC_FULL_PCT  = 7'd100;
   localparam logic               CMD_STOP      = 1'b1;
   localparam logic [1:0]         PHASE_FAST    = 2'd1;
   localparam logic [1:0]         PHASE_TAPER   = 2'd2;

   // register reset values
   localparam logic [12:0] RST_VBAT_LIMIT = 13'd8191;
   localparam logic [12:0] RST_VBAT_CLEAR = 13'd0;
   localparam logic [13:0] RST_IBAT_RATED = 14'd16383;
   localparam logic [13:0] RST_IBAT_MARGIN = 14'd0;
   localparam logic [13:0] RST_CV_RATED   = 14'd16383;
   localparam logic [11:0] RST_STEP       = 12'd100;
   localparam logic [12:0] RST_FV_CC      = 13'd4450;
   localparam logic [12:0] RST_FV_CV      = 13'd4430;

   typedef enum logic [2:0] {
      CSR_VBAT_LIMIT  = 3'd0,
      CSR_VBAT_CLEAR  = 3'd1,
      CSR_IBAT_RATED  = 3'd2,
      CSR_IBAT_MARGIN = 3'd3,
      CSR_CV_RATED    = 3'd4,
      CSR_STEP        = 3'd5,
      CSR_FV_CC       = 3'd6,
      CSR_FV_CV       = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      VOTE_NONE    = 2'd0,
      VOTE_SET     = 2'd1,
      VOTE_RELEASE = 2'd2
   } vote_op_type;

   typedef enum logic [2:0] {
      STAT_NODATA    = 3'd0,
      STAT_UNDERV    = 3'd1,
      STAT_UNDERRATE = 3'd2,
      STAT_TAPER     = 3'd3,
      STAT_REDUCED   = 3'd4,
      STAT_STOPPED   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_COMP,
      ST_IRDIV,
      ST_EVAL,
      ST_STEPDIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_W-1:0]     quot;
      logic [DIVISOR_W-1:0] rem;
   } div_rsp_type;

endpackage

[hdl/bvcl_div.sv]
// ----------------------------------------------------------------------------
// bvcl_div
// Restoring divider, one quotient bit per cycle, used for the cap-step
// quantisation.
// ----------------------------------------------------------------------------
module bvcl_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bvcl_pkg::div_req_type div_req,
   output bvcl_pkg::div_rsp_type div_rsp
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [bvcl_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [bvcl_pkg::DIV_W-1:0]       q_ff, q_in;
   logic [bvcl_pkg::DIVISOR_W-1:0]   r_ff, r_in;
   logic [bvcl_pkg::DIVISOR_W-1:0]   dvs_ff, dvs_in;
   logic [bvcl_pkg::DIVISOR_W:0]     trial;
   logic                             ge;

   always_comb begin
      trial   = {r_ff, q_ff[bvcl_pkg::DIV_W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = bvcl_pkg::DIV_CNT_W'(bvcl_pkg::DIV_W - 1);
         q_in    = div_req.dividend;
         r_in    = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         q_in = {q_ff[bvcl_pkg::DIV_W-2:0], ge};
         r_in = ge ? bvcl_pkg::DIVISOR_W'(trial - {1'b0, dvs_ff})
                   : trial[bvcl_pkg::DIVISOR_W-1:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = q_ff;
   assign div_rsp.rem  = r_ff;

endmodule

[hdl/battery_voltage_current_limiter.sv]
// ----------------------------------------------------------------------------
// battery_voltage_current_limiter
// Charger poll evaluation: IR-drop compensation, C-rate checks, quantised
// current cap reduction and CC/CV float voltage selection.
// ----------------------------------------------------------------------------
// One item in flight at a time; req_ready is high only while the sequencer is
// idle. A stop, no-data or plain poll item goes through the multiply, compare,
// evaluate and done states before rsp_valid rises. IR compensation adds the
// IR-divide state (product / 1000 by reciprocal multiplication), and a cap
// reduction with a nonzero step that does not bottom out at zero adds a pass
// through the radix-2 divider (remainder by the step). A finished result sits
// in the rsp register while the next item is accepted; a result still waiting
// there holds the sequencer.
// ----------------------------------------------------------------------------
module battery_voltage_current_limiter (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [13:0] csr_wdata,
   // request
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic        req_sample_valid,
   input  logic [12:0] req_vbat_mv,
   input  logic [13:0] req_icap_ma,
   input  logic signed [14:0] req_ibat_ma,
   input  logic [1:0]  req_charge_phase,
   input  logic [6:0]  req_soc_pct,
   input  logic        req_charger_weak,
   input  logic        req_irc_on,
   input  logic [10:0] req_irc_code,
   input  logic [12:0] req_profile_fv_mv,
   // response
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_vote_op,
   output logic [13:0] rsp_vote_ma,
   output logic        rsp_fv_write,
   output logic [12:0] rsp_fv_mv,
   output logic [2:0]  rsp_status
);

   // configuration registers
   logic [12:0] vbat_limit_ff, vbat_clear_ff, fv_cc_ff, fv_cv_ff;
   logic [13:0] ibat_rated_ff, ibat_margin_ff, cv_rated_ff;
   logic [11:0] step_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vbat_limit_ff  <= bvcl_pkg::RST_VBAT_LIMIT;
         vbat_clear_ff  <= bvcl_pkg::RST_VBAT_CLEAR;
         ibat_rated_ff  <= bvcl_pkg::RST_IBAT_RATED;
         ibat_margin_ff <= bvcl_pkg::RST_IBAT_MARGIN;
         cv_rated_ff    <= bvcl_pkg::RST_CV_RATED;
         step_ff        <= bvcl_pkg::RST_STEP;
         fv_cc_ff       <= bvcl_pkg::RST_FV_CC;
         fv_cv_ff       <= bvcl_pkg::RST_FV_CV;
      end else if (csr_valid) begin
         unique case (bvcl_pkg::csr_index_type'(csr_index))
            bvcl_pkg::CSR_VBAT_LIMIT:  vbat_limit_ff  <= csr_wdata[12:0];
            bvcl_pkg::CSR_VBAT_CLEAR:  vbat_clear_ff  <= csr_wdata[12:0];
            bvcl_pkg::CSR_IBAT_RATED:  ibat_rated_ff  <= csr_wdata;
            bvcl_pkg::CSR_IBAT_MARGIN: ibat_margin_ff <= csr_wdata;
            bvcl_pkg::CSR_CV_RATED:    cv_rated_ff    <= csr_wdata;
            bvcl_pkg::CSR_STEP:        step_ff        <= csr_wdata[11:0];
            bvcl_pkg::CSR_FV_CC:       fv_cc_ff       <= csr_wdata[12:0];
            default:                   fv_cv_ff       <= csr_wdata[12:0];
         endcase
      end
   end

   // captured item
   logic              cmd_ff, sval_ff, weak_ff, irc_on_ff;
   logic [12:0]       vbat_ff, profile_ff;
   logic [13:0]       icap_ff;
   logic signed [14:0] ibat_ff;
   logic [1:0]        phase_ff;
   logic [6:0]        soc_ff;
   logic [10:0]       code_ff;

   logic req_take;
   assign req_take = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff     <= req_cmd;
         sval_ff    <= req_sample_valid;
         vbat_ff    <= req_vbat_mv;
         icap_ff    <= req_icap_ma;
         ibat_ff    <= req_ibat_ma;
         phase_ff   <= req_charge_phase;
         soc_ff     <= req_soc_pct;
         weak_ff    <= req_charger_weak;
         irc_on_ff  <= req_irc_on;
         code_ff    <= req_irc_code;
         profile_ff <= req_profile_fv_mv;
      end
   end

   // sequencer and datapath
   bvcl_pkg::state_type   state_ff, state_in;
   bvcl_pkg::div_req_type div_req;
   bvcl_pkg::div_rsp_type div_rsp;

   logic                held_ff, held_in;
   logic signed [25:0]  prod_ff, prod_in;
   logic                apply_ff, apply_in;
   logic signed [15:0]  irq_ff, irq_in;
   logic [13:0]         irq_mag_ff, irq_mag_in;
   logic [13:0]         d_ff, d_in;
   logic                neg_ff, neg_in;
   logic [1:0]          res_op_ff, res_op_in;
   logic [13:0]         res_ma_ff, res_ma_in;
   logic                res_fvw_ff, res_fvw_in;
   logic [12:0]         res_fv_ff, res_fv_in;
   logic [2:0]          res_st_ff, res_st_in;
   logic                rsp_valid_ff, rsp_valid_in, rsp_load;

   // combinational helpers
   logic [9:0]          res_mohm;
   logic                irc_full;
   logic [25:0]         prod_mag;
   logic [42:0]         irc_recip;
   logic signed [15:0]  virc;
   logic signed [14:0]  rate_lim;
   logic [12:0]         step_eff;
   logic                soc_full;
   logic                fv_apply, want_cv;
   logic [12:0]         fv_target;

   always_comb begin
      if (code_ff >= bvcl_pkg::IRC_RANGE_2) begin
         res_mohm = 10'(code_ff - bvcl_pkg::IRC_RANGE_2);
      end else if (code_ff >= bvcl_pkg::IRC_RANGE_1) begin
         res_mohm = 10'(code_ff - bvcl_pkg::IRC_RANGE_1);
      end else begin
         res_mohm = code_ff[9:0];
      end
   end

   assign irc_full = code_ff >= bvcl_pkg::IRC_RANGE_1;
   assign prod_mag = prod_ff[25] ? 26'(-prod_ff) : 26'(prod_ff);
   // |product| / 1000 taken as (|product| / 8) / 125, quotient in bits 41:28
   assign irc_recip = prod_mag[23:3] * bvcl_pkg::IRC_DIV_RECIP;
   assign virc     = $signed({3'b000, vbat_ff}) - irq_ff;
   assign rate_lim = $signed({1'b0, ibat_rated_ff}) - $signed({1'b0, ibat_margin_ff});
   assign step_eff = (ibat_ff > bvcl_pkg::STEP_DBL_MA) ? {step_ff, 1'b0} : {1'b0, step_ff};
   assign soc_full = soc_ff >= bvcl_pkg::SOC_FULL_PCT;
   assign fv_target = (want_cv || weak_ff) ? fv_cv_ff : fv_cc_ff;

   always_comb begin
      state_in   = state_ff;
      held_in    = held_ff;
      prod_in    = prod_ff;
      apply_in   = apply_ff;
      irq_in     = irq_ff;
      irq_mag_in = irq_mag_ff;
      d_in       = d_ff;
      neg_in     = neg_ff;
      res_op_in  = res_op_ff;
      res_ma_in  = res_ma_ff;
      res_fvw_in = res_fvw_ff;
      res_fv_in  = res_fv_ff;
      res_st_in  = res_st_ff;
      fv_apply   = 1'b0;
      want_cv    = 1'b0;
      rsp_load   = 1'b0;
      div_req    = '0;

      unique case (state_ff)
         bvcl_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = bvcl_pkg::ST_MUL;
            end
         end

         bvcl_pkg::ST_MUL: begin
            prod_in  = ibat_ff * $signed({1'b0, res_mohm});
            apply_in = (cmd_ff != bvcl_pkg::CMD_STOP) && sval_ff && irc_on_ff
                       && (phase_ff == bvcl_pkg::PHASE_FAST) && (res_mohm != '0)
                       && (vbat_ff <= bvcl_pkg::MAX_IRC_MV)
                       && (irc_full || !(ibat_ff < $signed({1'b0, ibat_rated_ff})));
            state_in = bvcl_pkg::ST_COMP;
         end

         bvcl_pkg::ST_COMP: begin
            neg_in = prod_ff[25];
            if (apply_ff) begin
               irq_mag_in = irc_recip[41:28];
               state_in   = bvcl_pkg::ST_IRDIV;
            end else begin
               irq_in   = '0;
               state_in = bvcl_pkg::ST_EVAL;
            end
         end

         bvcl_pkg::ST_IRDIV: begin
            irq_in   = neg_ff ? -$signed({2'b00, irq_mag_ff})
                              :  $signed({2'b00, irq_mag_ff});
            state_in = bvcl_pkg::ST_EVAL;
         end

         bvcl_pkg::ST_EVAL: begin
            res_op_in = bvcl_pkg::VOTE_NONE;
            res_ma_in = '0;
            state_in  = bvcl_pkg::ST_DONE;
            if (cmd_ff == bvcl_pkg::CMD_STOP) begin
               res_op_in = bvcl_pkg::VOTE_RELEASE;
               held_in   = 1'b0;
               fv_apply  = 1'b1;
               res_st_in = bvcl_pkg::STAT_STOPPED;
            end else if (!sval_ff) begin
               fv_apply  = soc_full;
               want_cv   = 1'b1;
               res_st_in = bvcl_pkg::STAT_NODATA;
            end else if (virc <= $signed({3'b000, vbat_limit_ff})) begin
               if (held_ff && (virc <= $signed({3'b000, vbat_clear_ff}))) begin
                  res_op_in = bvcl_pkg::VOTE_RELEASE;
                  held_in   = 1'b0;
               end
               fv_apply  = soc_full;
               want_cv   = 1'b1;
               res_st_in = bvcl_pkg::STAT_UNDERV;
            end else if ((phase_ff != bvcl_pkg::PHASE_TAPER)
                         && ($signed({1'b0, icap_ff}) <= rate_lim)) begin
               fv_apply  = soc_full;
               want_cv   = 1'b1;
               res_st_in = bvcl_pkg::STAT_UNDERRATE;
            end else if ((phase_ff == bvcl_pkg::PHASE_TAPER) && (icap_ff <= cv_rated_ff)) begin
               fv_apply  = 1'b1;
               want_cv   = 1'b1;
               res_st_in = bvcl_pkg::STAT_TAPER;
            end else begin
               res_op_in = bvcl_pkg::VOTE_SET;
               held_in   = 1'b1;
               fv_apply  = 1'b1;
               want_cv   = soc_full;
               res_st_in = bvcl_pkg::STAT_REDUCED;
               if (step_eff == '0) begin
                  res_ma_in = icap_ff;
               end else if (icap_ff < {1'b0, step_eff}) begin
                  res_ma_in = '0;
               end else begin
                  // quantise: (icap - step) rounded down to a multiple of step
                  d_in             = icap_ff - {1'b0, step_eff};
                  div_req.start    = 1'b1;
                  div_req.dividend = bvcl_pkg::DIV_W'(icap_ff - {1'b0, step_eff});
                  div_req.divisor  = step_eff;
                  state_in         = bvcl_pkg::ST_STEPDIV;
               end
            end
            res_fvw_in = bvcl_pkg::MULTI_FV_ON && fv_apply && (profile_ff != '0)
                         && (profile_ff != fv_target);
            res_fv_in  = res_fvw_in ? fv_target : '0;
         end

         bvcl_pkg::ST_STEPDIV: begin
            if (div_rsp.done) begin
               res_ma_in = d_ff - {1'b0, div_rsp.rem};
               state_in  = bvcl_pkg::ST_DONE;
            end
         end

         bvcl_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = bvcl_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bvcl_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bvcl_pkg::ST_IDLE;
         held_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      apply_ff   <= apply_in;
      irq_ff     <= irq_in;
      irq_mag_ff <= irq_mag_in;
      d_ff       <= d_in;
      neg_ff     <= neg_in;
      res_op_ff  <= res_op_in;
      res_ma_ff  <= res_ma_in;
      res_fvw_ff <= res_fvw_in;
      res_fv_ff  <= res_fv_in;
      res_st_ff  <= res_st_in;
   end

   // output item register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_vote_op  <= res_op_ff;
         rsp_vote_ma  <= res_ma_ff;
         rsp_fv_write <= res_fvw_ff;
         rsp_fv_mv    <= res_fv_ff;
         rsp_status   <= res_st_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == bvcl_pkg::ST_IDLE);

   bvcl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

[verif/tb_battery_voltage_current_limiter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_battery_voltage_current_limiter
// Self-checking bench for the charger poll limiter. A clocked driver feeds
// poll and stop items from a backlog, a clocked monitor predicts the vote,
// float voltage and status of every accepted item and compares them with the
// results. Runs through several register settings with random gaps on both
// sides, including a long response hold-off.
// ----------------------------------------------------------------------------
module tb_battery_voltage_current_limiter;

   localparam int CYCLE_LIMIT = 900000;
   localparam int LONG_HOLD   = 300;
   localparam int END_SETTLE  = 60;

   typedef struct {
      logic               cmd;
      logic               sample_valid;
      logic [12:0]        vbat_mv;
      logic [13:0]        icap_ma;
      logic signed [14:0] ibat_ma;
      logic [1:0]         charge_phase;
      logic [6:0]         soc_pct;
      logic               charger_weak;
      logic               irc_on;
      logic [10:0]        irc_code;
      logic [12:0]        profile_fv_mv;
   } charger_poll_type;

   typedef struct {
      bvcl_pkg::vote_op_type op;
      logic [13:0]           ma;
      logic                  fv_write;
      logic [12:0]           fv;
      bvcl_pkg::status_type  st;
   } limit_vote_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [13:0] csr_wdata = '0;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_cmd = 1'b0;
   logic               req_sample_valid = 1'b0;
   logic [12:0]        req_vbat_mv = '0;
   logic [13:0]        req_icap_ma = '0;
   logic signed [14:0] req_ibat_ma = '0;
   logic [1:0]         req_charge_phase = '0;
   logic [6:0]         req_soc_pct = '0;
   logic               req_charger_weak = 1'b0;
   logic               req_irc_on = 1'b0;
   logic [10:0]        req_irc_code = '0;
   logic [12:0]        req_profile_fv_mv = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_vote_op;
   logic [13:0] rsp_vote_ma;
   logic        rsp_fv_write;
   logic [12:0] rsp_fv_mv;
   logic [2:0]  rsp_status;

   // limiter settings and vote state as the bench sees them
   logic [12:0] cfg_vbat_limit  = bvcl_pkg::RST_VBAT_LIMIT;
   logic [12:0] cfg_vbat_clear  = bvcl_pkg::RST_VBAT_CLEAR;
   logic [13:0] cfg_ibat_rated  = bvcl_pkg::RST_IBAT_RATED;
   logic [13:0] cfg_ibat_margin = bvcl_pkg::RST_IBAT_MARGIN;
   logic [13:0] cfg_cv_rated    = bvcl_pkg::RST_CV_RATED;
   logic [11:0] cfg_step        = bvcl_pkg::RST_STEP;
   logic [12:0] cfg_fv_cc       = bvcl_pkg::RST_FV_CC;
   logic [12:0] cfg_fv_cv       = bvcl_pkg::RST_FV_CV;
   logic        limit_held      = 1'b0;

   charger_poll_type poll_backlog[$];
   limit_vote_type   vote_expected[$];

   logic req_taken     = 1'b0;
   int   req_gap       = 0;
   int   rsp_gap       = 0;
   int   hold_left     = 0;
   int   hold_requests = 0;
   int   hold_served   = 0;
   logic idle_on       = 1'b1;
   int   mismatches    = 0;
   int   cycle_count   = 0;

   battery_voltage_current_limiter i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_sample_valid  (req_sample_valid),
      .req_vbat_mv       (req_vbat_mv),
      .req_icap_ma       (req_icap_ma),
      .req_ibat_ma       (req_ibat_ma),
      .req_charge_phase  (req_charge_phase),
      .req_soc_pct       (req_soc_pct),
      .req_charger_weak  (req_charger_weak),
      .req_irc_on        (req_irc_on),
      .req_irc_code      (req_irc_code),
      .req_profile_fv_mv (req_profile_fv_mv),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_vote_op       (rsp_vote_op),
      .rsp_vote_ma       (rsp_vote_ma),
      .rsp_fv_write      (rsp_fv_write),
      .rsp_fv_mv         (rsp_fv_mv),
      .rsp_status        (rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic limit_vote_type float_select(limit_vote_type r, logic want_cv,
                                                   charger_poll_type p);
      logic [12:0] target;
      r.fv_write = 1'b0;
      r.fv       = '0;
      if (bvcl_pkg::MULTI_FV_ON) begin
         target = (want_cv || p.charger_weak) ? cfg_fv_cv : cfg_fv_cc;
         if (p.profile_fv_mv != 0 && p.profile_fv_mv != target) begin
            r.fv_write = 1'b1;
            r.fv       = target;
         end
      end
      return r;
   endfunction

   function automatic limit_vote_type evaluate_poll(charger_poll_type p);
      limit_vote_type r;
      int   vbat, icap, ibat, res, virc, step, cap_new;
      logic full_range, soc_full;
      r.op       = bvcl_pkg::VOTE_NONE;
      r.ma       = '0;
      r.fv_write = 1'b0;
      r.fv       = '0;
      r.st       = bvcl_pkg::STAT_NODATA;
      vbat       = int'(p.vbat_mv);
      icap       = int'(p.icap_ma);
      ibat       = $signed(p.ibat_ma);
      res        = int'(p.irc_code) % 1000;
      full_range = p.irc_code >= bvcl_pkg::IRC_RANGE_1;
      soc_full   = p.soc_pct >= bvcl_pkg::SOC_FULL_PCT;

      if (p.cmd == bvcl_pkg::CMD_STOP) begin
         r.op       = bvcl_pkg::VOTE_RELEASE;
         limit_held = 1'b0;
         r          = float_select(r, 1'b0, p);
         r.st       = bvcl_pkg::STAT_STOPPED;
         return r;
      end
      if (!p.sample_valid) begin
         if (soc_full) r = float_select(r, 1'b1, p);
         r.st = bvcl_pkg::STAT_NODATA;
         return r;
      end

      virc = vbat;
      if (p.irc_on && p.charge_phase == bvcl_pkg::PHASE_FAST && res > 0
          && vbat <= int'(bvcl_pkg::MAX_IRC_MV)) begin
         virc = vbat - (ibat * res) / 1000;
         if (!full_range && ibat < int'(cfg_ibat_rated)) virc = vbat;
      end

      if (virc <= int'(cfg_vbat_limit)) begin
         if (limit_held && virc <= int'(cfg_vbat_clear)) begin
            r.op       = bvcl_pkg::VOTE_RELEASE;
            limit_held = 1'b0;
         end
         if (soc_full) r = float_select(r, 1'b1, p);
         r.st = bvcl_pkg::STAT_UNDERV;
         return r;
      end
      if (p.charge_phase != bvcl_pkg::PHASE_TAPER
          && icap <= int'(cfg_ibat_rated) - int'(cfg_ibat_margin)) begin
         if (soc_full) r = float_select(r, 1'b1, p);
         r.st = bvcl_pkg::STAT_UNDERRATE;
         return r;
      end
      if (p.charge_phase == bvcl_pkg::PHASE_TAPER && icap <= int'(cfg_cv_rated)) begin
         r    = float_select(r, 1'b1, p);
         r.st = bvcl_pkg::STAT_TAPER;
         return r;
      end

      step = int'(cfg_step);
      if (ibat > int'(bvcl_pkg::STEP_DBL_MA)) step = step * 2;
      if (step == 0) cap_new = icap;
      else cap_new = (icap - step) / step * step;
      if (cap_new < 0) cap_new = 0;
      r.op       = bvcl_pkg::VOTE_SET;
      r.ma       = cap_new[13:0];
      limit_held = 1'b1;
      r          = float_select(r, soc_full, p);
      r.st       = bvcl_pkg::STAT_REDUCED;
      return r;
   endfunction

   task automatic apply_register(bvcl_pkg::csr_index_type idx, logic [13:0] val);
      case (idx)
         bvcl_pkg::CSR_VBAT_LIMIT:  cfg_vbat_limit  = val[12:0];
         bvcl_pkg::CSR_VBAT_CLEAR:  cfg_vbat_clear  = val[12:0];
         bvcl_pkg::CSR_IBAT_RATED:  cfg_ibat_rated  = val;
         bvcl_pkg::CSR_IBAT_MARGIN: cfg_ibat_margin = val;
         bvcl_pkg::CSR_CV_RATED:    cfg_cv_rated    = val;
         bvcl_pkg::CSR_STEP:        cfg_step        = val[11:0];
         bvcl_pkg::CSR_FV_CC:       cfg_fv_cc       = val[12:0];
         default:                   cfg_fv_cv       = val[12:0];
      endcase
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int clip(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic charger_poll_type poll_at(int vbat, int icap, int ibat, int phase,
                                                int soc, logic irc_on, int code,
                                                int profile);
      charger_poll_type p;
      p.cmd           = ~bvcl_pkg::CMD_STOP;
      p.sample_valid  = 1'b1;
      p.vbat_mv       = vbat[12:0];
      p.icap_ma       = icap[13:0];
      p.ibat_ma       = ibat[14:0];
      p.charge_phase  = phase[1:0];
      p.soc_pct       = soc[6:0];
      p.charger_weak  = 1'b0;
      p.irc_on        = irc_on;
      p.irc_code      = code[10:0];
      p.profile_fv_mv = profile[12:0];
      return p;
   endfunction

   function automatic charger_poll_type random_poll();
      charger_poll_type p;
      int r, vbat, icap, ibat, code, profile, soc;
      r = $urandom_range(0, 99);
      if (r < 45) vbat = clip(int'(cfg_vbat_limit) + $urandom_range(0, 600) - 300, 8191);
      else if (r < 65) vbat = clip(int'(cfg_vbat_clear) + $urandom_range(0, 400) - 200, 8191);
      else if (r < 80) vbat = $urandom_range(4300, 4500);
      else vbat = $urandom_range(0, 8191);

      r = $urandom_range(0, 99);
      if (r < 40) icap = $urandom_range(0, 16383);
      else if (r < 70)
         icap = clip(int'(cfg_ibat_rated) - int'(cfg_ibat_margin)
                     + $urandom_range(0, 400) - 200, 16383);
      else icap = clip(int'(cfg_cv_rated) + $urandom_range(0, 400) - 200, 16383);

      r = $urandom_range(0, 99);
      if (r < 50) ibat = $urandom_range(0, 4000);
      else if (r < 70) ibat = $urandom_range(2900, 3500);
      else if (r < 85) ibat = -int'($urandom_range(0, 16384));
      else ibat = int'($urandom_range(0, 32767)) - 16384;

      r = $urandom_range(0, 99);
      if (r < 40) code = $urandom_range(0, 1999);
      else if (r < 80) code = $urandom_range(1, 200);
      else code = $urandom_range(1000, 1200);

      r = $urandom_range(0, 99);
      if (r < 30) profile = 0;
      else if (r < 60) profile = cfg_fv_cc;
      else if (r < 90) profile = cfg_fv_cv;
      else profile = $urandom_range(0, 8191);

      soc = ($urandom_range(0, 1) == 0) ? $urandom_range(95, 105) : $urandom_range(0, 127);

      p = poll_at(vbat, icap, ibat, ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2),
                  soc, $urandom_range(0, 1), code, profile);
      p.charger_weak = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 4) p.cmd = bvcl_pkg::CMD_STOP;
      else if (r < 9) p.sample_valid = 1'b0;
      return p;
   endfunction

   task automatic feed_random(int count);
      @(posedge clock);
      repeat (count) poll_backlog.push_back(random_poll());
   endtask

   // sender stays quiet until every expected result is back
   task automatic drain();
      do @(posedge clock);
      while (poll_backlog.size() != 0 || req_valid || vote_expected.size() != 0);
   endtask

   task automatic write_register(bvcl_pkg::csr_index_type idx, int val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[13:0];
      do @(posedge clock);
      while (!csr_ready);
      apply_register(idx, val[13:0]);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_all(int limit, int clear, int rated, int margin, int cv_rated,
                            int step, int fv_cc, int fv_cv);
      write_register(bvcl_pkg::CSR_VBAT_LIMIT, limit);
      write_register(bvcl_pkg::CSR_VBAT_CLEAR, clear);
      write_register(bvcl_pkg::CSR_IBAT_RATED, rated);
      write_register(bvcl_pkg::CSR_IBAT_MARGIN, margin);
      write_register(bvcl_pkg::CSR_CV_RATED, cv_rated);
      write_register(bvcl_pkg::CSR_STEP, step);
      write_register(bvcl_pkg::CSR_FV_CC, fv_cc);
      write_register(bvcl_pkg::CSR_FV_CV, fv_cv);
   endtask

   task automatic flag_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   // ------------------------------------------------------------------------
   // driver, response pacing, monitor
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : req_driver
      charger_poll_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (poll_backlog.size() != 0) begin
            it = poll_backlog.pop_front();
            req_cmd           <= it.cmd;
            req_sample_valid  <= it.sample_valid;
            req_vbat_mv       <= it.vbat_mv;
            req_icap_ma       <= it.icap_ma;
            req_ibat_ma       <= it.ibat_ma;
            req_charge_phase  <= it.charge_phase;
            req_soc_pct       <= it.soc_pct;
            req_charger_weak  <= it.charger_weak;
            req_irc_on        <= it.irc_on;
            req_irc_code      <= it.irc_code;
            req_profile_fv_mv <= it.profile_fv_mv;
            req_valid         <= 1'b1;
            req_gap           <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : rsp_pacer
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= LONG_HOLD;
         rsp_ready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap   <= rsp_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_gap <= pick_gap();
      end
   end

   always @(posedge clock) begin : bus_monitor
      charger_poll_type seen;
      limit_vote_type   want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (vote_expected.size() == 0) begin
               flag_mismatch("unexpected item", 1, 0);
            end else begin
               want = vote_expected.pop_front();
               if (rsp_vote_op !== want.op) flag_mismatch("vote_op", rsp_vote_op, want.op);
               if (rsp_vote_ma !== want.ma) flag_mismatch("vote_ma", rsp_vote_ma, want.ma);
               if (rsp_fv_write !== want.fv_write)
                  flag_mismatch("fv_write", rsp_fv_write, want.fv_write);
               if (rsp_fv_mv !== want.fv) flag_mismatch("fv_mv", rsp_fv_mv, want.fv);
               if (rsp_status !== want.st) flag_mismatch("status", rsp_status, want.st);
            end
         end
         if (req_valid && req_ready) begin
            seen.cmd           = req_cmd;
            seen.sample_valid  = req_sample_valid;
            seen.vbat_mv       = req_vbat_mv;
            seen.icap_ma       = req_icap_ma;
            seen.ibat_ma       = req_ibat_ma;
            seen.charge_phase  = req_charge_phase;
            seen.soc_pct       = req_soc_pct;
            seen.charger_weak  = req_charger_weak;
            seen.irc_on        = req_irc_on;
            seen.irc_code      = req_irc_code;
            seen.profile_fv_mv = req_profile_fv_mv;
            vote_expected.push_back(evaluate_poll(seen));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin : sequencer
      charger_poll_type d;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset settings: nearly everything sits under the voltage limit
      feed_random(40);
      drain();

      // typical settings, then the directed items
      write_all(3800, 3500, 3000, 200, 1500, 100, 4350, 4300);
      @(posedge clock);
      d = poll_at(4000, 3000, 1000, 1, 50, 1'b0, 0, 4400);
      d.cmd = bvcl_pkg::CMD_STOP;                             // stop, nothing held
      poll_backlog.push_back(d);
      d = poll_at(4000, 3000, 1000, 1, 100, 1'b0, 0, 8191);
      d.sample_valid = 1'b0;                                  // no data, full soc
      poll_backlog.push_back(d);
      d.soc_pct = 0;
      poll_backlog.push_back(d);
      poll_backlog.push_back(poll_at(0, 3000, 1000, 1, 50, 1'b0, 0, 0));
      poll_backlog.push_back(poll_at(8191, 16383, 1000, 1, 127, 1'b0, 0, 4300));
      poll_backlog.push_back(poll_at(4000, 2850, 3201, 1, 50, 1'b0, 0, 0)); // doubled step
      poll_backlog.push_back(poll_at(3500, 3000, 1000, 1, 50, 1'b0, 0, 0)); // release
      poll_backlog.push_back(poll_at(3800, 3000, 1000, 1, 50, 1'b0, 0, 0));
      poll_backlog.push_back(poll_at(4000, 2800, 1000, 0, 50, 1'b0, 0, 0)); // under rate
      poll_backlog.push_back(poll_at(4000, 2800, 1000, 3, 50, 1'b0, 0, 0)); // phase 3
      poll_backlog.push_back(poll_at(4000, 1500, 1000, 2, 50, 1'b0, 0, 4350)); // taper hold
      poll_backlog.push_back(poll_at(4000, 1501, 1000, 2, 50, 1'b0, 0, 0));
      poll_backlog.push_back(poll_at(4400, 3000, 1000, 1, 50, 1'b1, 1999, 0)); // full range
      poll_backlog.push_back(poll_at(4400, 3000, 2999, 1, 50, 1'b1, 500, 0));
      poll_backlog.push_back(poll_at(4400, 3000, 3000, 1, 50, 1'b1, 500, 0));
      poll_backlog.push_back(poll_at(4401, 16383, 16383, 1, 50, 1'b1, 1999, 0));
      poll_backlog.push_back(poll_at(3000, 3000, -16384, 1, 50, 1'b1, 1100, 0));
      poll_backlog.push_back(poll_at(3000, 3000, 5000, 1, 50, 1'b1, 1000, 0)); // zero ohm
      poll_backlog.push_back(poll_at(4000, 3000, 5000, 2, 50, 1'b1, 1999, 0));
      d = poll_at(4000, 3000, 1000, 1, 10, 1'b0, 0, 4350);
      d.cmd          = bvcl_pkg::CMD_STOP;
      d.charger_weak = 1'b1;                                  // weak charger forces CV
      poll_backlog.push_back(d);
      d.cmd = ~bvcl_pkg::CMD_STOP;
      poll_backlog.push_back(d);
      d.cmd = bvcl_pkg::CMD_STOP;                             // stop with a vote held
      d.charger_weak = 1'b0;
      poll_backlog.push_back(d);
      feed_random(250);
      drain();

      // low extremes, no idling at all
      idle_on = 1'b0;
      write_all(0, 0, 0, 0, 0, 1, 0, 8191);
      feed_random(150);
      drain();
      idle_on = 1'b1;

      // high extremes: clear above limit, cap reductions below the step saturate at zero
      write_all(4000, 8191, 16383, 16383, 16383, 4095, 8191, 0);
      feed_random(150);
      drain();

      // zero step keeps the cap; receiver holds off while items keep coming
      write_all(3800, 3500, 3000, 200, 1500, 0, 4450, 4430);
      feed_random(120);
      hold_requests++;
      drain();

      write_all(3700, 3300, 2500, 500, 1200, 250, 4400, 4350);
      feed_random(370);
      hold_requests++;
      drain();

      repeat (END_SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[battery_voltage_current_limiter.f]
hdl/bvcl_pkg.sv
hdl/bvcl_div.sv
hdl/battery_voltage_current_limiter.sv
verif/tb_battery_voltage_current_limiter.sv
